// File: rtl/core/cswt_pkg.sv
// ----------------------------------------------------------------------------
// cswt_pkg: shared types and constants
// Widths, action and status codes, and the front-to-back request record.
// ----------------------------------------------------------------------------
package cswt_pkg;

  localparam int unsigned Clients    = 256;
  localparam int unsigned Windows    = 16;
  localparam int unsigned ClientW    = $clog2(Clients);
  localparam int unsigned WinW       = (Windows > 1) ? $clog2(Windows) : 1;
  localparam int unsigned AddrW      = 48;
  localparam int unsigned RowW       = 2 * AddrW * Windows;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [2:0] {
    ACT_OPEN     = 3'd0,
    ACT_CLOSE    = 3'd1,
    ACT_EXPORT   = 3'd2,
    ACT_UNEXPORT = 3'd3,
    ACT_CHECK    = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_BUSY      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_NO_SLOT   = 3'd4,
    ST_NOT_OPEN  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    OP_DONE,      // status fixed in the front, no row access
    OP_CLOSE,
    OP_EXPORT,
    OP_UNEXPORT
  } op_e;

  // Request as classified by the front part.
  typedef struct packed {
    op_e                op;
    logic [2:0]         status;
    logic [7:0]         slot;
    logic               in_use;
    logic [ClientW-1:0] client;
    logic [AddrW-1:0]   address;
    logic [AddrW-1:0]   byte_count;
    logic               check;
  } req_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [7:0]       slot;
    logic [AddrW-1:0] granted;
  } res_t;

endpackage

// File: rtl/core/cswt_ram.sv
// ----------------------------------------------------------------------------
// cswt_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module cswt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_o <= mem_q[addr_i];
    end
  end
endmodule

// File: rtl/core/cswt_front.sv
// ----------------------------------------------------------------------------
// cswt_front: request intake and slot bookkeeping
// Hold the in-use bits, grant slots, classify requests into the queue.
// ----------------------------------------------------------------------------
module cswt_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  output logic                       full_o,
  input  logic [2:0]                 action_i,
  input  logic [7:0]                 client_i,
  input  logic [cswt_pkg::AddrW-1:0] address_i,
  input  logic [cswt_pkg::AddrW-1:0] byte_count_i,
  input  logic                       clr_ready_i,
  output logic                       q_push_o,
  output cswt_pkg::req_t             q_req_o,
  input  logic                       q_full_i
);
  import cswt_pkg::*;

  logic [Clients-1:0] in_use_q, in_use_d;
  logic [ClientW-1:0] free_idx;
  logic               free_found;
  logic               client_ok;
  logic [ClientW-1:0] cl;
  req_t               req;

  assign full_o   = q_full_i | ~clr_ready_i;
  assign q_push_o = push_i & ~full_o;
  assign q_req_o  = req;
  assign cl       = ClientW'(client_i);
  assign client_ok = (32'(client_i) < Clients);

  // Lowest free slot; priority encoder over the bit vector.
  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = Clients - 1; i >= 0; i--) begin
      if (!in_use_q[i]) begin
        free_idx   = ClientW'(i);
        free_found = 1'b1;
      end
    end
  end

  always_comb begin
    in_use_d       = in_use_q;
    req.op         = OP_DONE;
    req.status     = ST_INVALID;
    req.slot       = '0;
    req.in_use     = in_use_q[cl];
    req.client     = cl;
    req.address    = address_i;
    req.byte_count = byte_count_i;
    req.check      = 1'b0;
    if (action_i == ACT_OPEN) begin
      req.status = free_found ? ST_OK : ST_NO_SLOT;
      req.slot   = free_found ? 8'(free_idx) : 8'd0;
      if (free_found) in_use_d[free_idx] = 1'b1;
    end else if (client_ok && action_i <= ACT_CHECK) begin
      case (action_i)
        ACT_CLOSE: begin
          req.op       = OP_CLOSE;
          req.status   = ST_OK;
          in_use_d[cl] = 1'b0;
        end
        ACT_EXPORT: begin
          if (byte_count_i != '0) req.op = OP_EXPORT;
        end
        ACT_UNEXPORT: req.op = OP_UNEXPORT;
        default: begin
          if (in_use_q[cl]) begin
            req.op    = OP_UNEXPORT;
            req.check = 1'b1;
          end else begin
            req.status = ST_NOT_OPEN;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= '0;
    end else if (q_push_o) begin
      in_use_q <= in_use_d;
    end
  end
endmodule

// File: rtl/core/cswt_queue.sv
// ----------------------------------------------------------------------------
// cswt_queue: small FIFO between front and back
// Queue of req_t records, registers only.
// ----------------------------------------------------------------------------
module cswt_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cswt_pkg::req_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output cswt_pkg::req_t data_o,
  output logic           empty_o
);
  import cswt_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  req_t            buf_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (PtrW+1)'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = buf_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) buf_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
    end
  end
endmodule

// File: rtl/core/cswt_back.sv
// ----------------------------------------------------------------------------
// cswt_back: window table engine
// Read a client's row, match all windows in parallel, write back, report.
// ----------------------------------------------------------------------------
module cswt_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_empty_i,
  input  cswt_pkg::req_t             q_req_i,
  output logic                       q_pop_o,
  output logic                       clr_ready_o,
  output logic                       res_valid_o,
  output cswt_pkg::res_t             res_o,
  input  logic                       res_taken_i
);
  import cswt_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_OUT
  } state_e;

  state_e             state_q;
  logic [ClientW-1:0] clr_q;
  req_t               req_q;
  res_t               res_q;

  logic               we;
  logic [ClientW-1:0] addr;
  logic [RowW-1:0]    wrow, rrow, new_row;
  logic [AddrW-1:0]   base [Windows];
  logic [AddrW-1:0]   size [Windows];
  logic [Windows-1:0] hit_free, hit_base, hit_ok;
  logic [AddrW:0]     acc_end;
  res_t               res_d;

  cswt_ram #(.Width(RowW), .Depth(Clients)) u_rows (
    .clk_i  (clk_i),
    .we_i   (we),
    .addr_i (addr),
    .wdata_i(wrow),
    .rdata_o(rrow)
  );

  assign acc_end = {1'b0, req_q.address} + {1'b0, req_q.byte_count};

  always_comb begin
    for (int w = 0; w < Windows; w++) begin
      logic [AddrW:0] hi;
      base[w]     = rrow[2*AddrW*w +: AddrW];
      size[w]     = rrow[2*AddrW*w + AddrW +: AddrW];
      hi          = {1'b0, base[w]} + {1'b0, size[w]};
      hit_free[w] = (size[w] == '0);
      hit_base[w] = (base[w] == req_q.address);
      hit_ok[w]   = (req_q.address >= base[w]) && ({1'b0, req_q.address} <= hi) &&
                    (acc_end >= {1'b0, base[w]}) && (acc_end <= hi);
    end
  end

  // Pick first matching entry and build the row to write back.
  always_comb begin
    logic done;
    logic [Windows-1:0] hits;
    done    = 1'b0;
    new_row = rrow;
    hits    = (req_q.op == OP_EXPORT) ? hit_free : hit_base;
    res_d   = '{status: ST_OK, slot: '0, granted: '0};
    for (int w = 0; w < Windows; w++) begin
      if (!done && hits[w]) begin
        done = 1'b1;
        new_row[2*AddrW*w +: 2*AddrW] = (req_q.op == OP_EXPORT) ?
            {req_q.byte_count, req_q.address} : '0;
      end
    end
    case (req_q.op)
      OP_EXPORT: begin
        res_d.status  = done ? ST_OK : ST_BUSY;
        res_d.granted = done ? req_q.address : '0;
      end
      OP_UNEXPORT: begin
        if (req_q.check) res_d.status = (|hit_ok) ? ST_OK : ST_INVALID;
        else             res_d.status = done ? ST_OK : ST_NOT_FOUND;
      end
      default: res_d.status = ST_OK;
    endcase
  end

  always_comb begin
    we   = 1'b0;
    addr = q_req_i.client;
    wrow = '0;
    case (state_q)
      S_CLEAR: begin
        we   = 1'b1;
        addr = clr_q;
      end
      S_IDLE: begin
        we = !q_empty_i && (q_req_i.op == OP_CLOSE);
      end
      S_READ: begin
        addr = req_q.client;
        wrow = new_row;
        we   = !req_q.check && (req_q.op != OP_DONE);
      end
      default: ;
    endcase
  end

  assign q_pop_o     = (state_q == S_IDLE) && !q_empty_i;
  assign clr_ready_o = (state_q != S_CLEAR);
  assign res_valid_o = (state_q == S_OUT);
  assign res_o       = res_q;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) req_q <= q_req_i;
    if (state_q == S_IDLE && !q_empty_i &&
        (q_req_i.op == OP_DONE || q_req_i.op == OP_CLOSE)) begin
      res_q <= '{status: q_req_i.status, slot: q_req_i.slot, granted: '0};
    end else if (state_q == S_READ) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
    end else begin
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == ClientW'(Clients - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (!q_empty_i) begin
            state_q <= (q_req_i.op == OP_DONE || q_req_i.op == OP_CLOSE) ?
                       S_OUT : S_READ;
          end
        end
        S_READ: state_q <= S_OUT;
        S_OUT:  if (res_taken_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// File: rtl/core/client_slot_and_dma_window_table.sv
// ----------------------------------------------------------------------------
// client_slot_and_dma_window_table: client slot and DMA window protection
// Top level: front intake, request queue, window-table back end.
// ----------------------------------------------------------------------------
// Each request gives exactly one result. Open and close, and requests whose
// answer is fixed up front, go from idle straight to the output state of the
// back end; export, unexport and check pass a read state first, set by the
// one-port row memory (read the whole client row, compare all windows in
// parallel, write back). A short queue lets the front accept requests while
// the back end is busy. After reset a clearing pass writes every row of the
// table, one row per cycle, and full stays high until it ends.
module client_slot_and_dma_window_table (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  logic [2:0]                 action_i,
  input  logic [7:0]                 client_i,
  input  logic [cswt_pkg::AddrW-1:0] address_i,
  input  logic [cswt_pkg::AddrW-1:0] byte_count_i,
  output logic                       empty,
  input  logic                       pop,
  output logic [2:0]                 status_o,
  output logic [7:0]                 slot_o,
  output logic [cswt_pkg::AddrW-1:0] granted_address_o
);
  import cswt_pkg::*;

  logic q_push, q_full, q_pop, q_empty, clr_ready, res_valid;
  req_t q_in, q_out;
  res_t res;

  cswt_front u_front (
    .clk_i, .rst_ni,
    .push_i      (push),
    .full_o      (full),
    .action_i, .client_i, .address_i, .byte_count_i,
    .clr_ready_i (clr_ready),
    .q_push_o    (q_push),
    .q_req_o     (q_in),
    .q_full_i    (q_full)
  );

  cswt_queue u_queue (
    .clk_i, .rst_ni,
    .push_i (q_push),
    .data_i (q_in),
    .full_o (q_full),
    .pop_i  (q_pop),
    .data_o (q_out),
    .empty_o(q_empty)
  );

  cswt_back u_back (
    .clk_i, .rst_ni,
    .q_empty_i  (q_empty),
    .q_req_i    (q_out),
    .q_pop_o    (q_pop),
    .clr_ready_o(clr_ready),
    .res_valid_o(res_valid),
    .res_o      (res),
    .res_taken_i(pop)
  );

  // Present the result register directly.
  assign empty             = ~res_valid;
  assign status_o          = res.status;
  assign slot_o            = res.slot;
  assign granted_address_o = res.granted;
endmodule
